>>> sv/yuvsa_pkg.sv
package yuvsa_pkg;

  localparam int DATA_W    = 14;
  localparam int FRAC_BITS = 12;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;
  localparam int ADDR_W    = 3;

  // YUV values after the forward matrix
  localparam int T_W = 16;
  // chroma after the gain, inverse matrix operands
  localparam int S_W = 19;
  // inverse matrix results before saturation
  localparam int R_W = 22;

  localparam int DATA_MAX = 8191;
  localparam int DATA_MIN = -8192;

  localparam logic [1:0] MODE_RGB2YUV = 2'd0;
  localparam logic [1:0] MODE_YUV2RGB = 2'd1;
  localparam logic [1:0] MODE_SAT     = 2'd2;

  localparam logic [1:0]        MODE_RESET = MODE_SAT;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  typedef struct packed {
    logic       vld;
    logic [1:0] mode;
  } ctl_t;

  typedef int milli_arr_t [9];

  localparam milli_arr_t FWD_MILLI = '{299, 587, 114, -147, -289, 436, 615, -515, -100};
  localparam milli_arr_t INV_MILLI = '{1000, 0, 1140, 1000, -395, -581, 1000, 2032, 0};

  // round(milli / 1000 * 2^frac), ties away from zero
  function automatic logic signed [31:0] coef_of(int milli, int frac);
    int mag;
    int q;
    mag = (milli < 0) ? -milli : milli;
    q   = ((mag << frac) + 500) / 1000;
    return (milli < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] fwd_coef(int idx, int frac);
    return coef_of(FWD_MILLI[idx], frac);
  endfunction

  function automatic logic signed [31:0] inv_coef(int idx, int frac);
    return coef_of(INV_MILLI[idx], frac);
  endfunction

endpackage

>>> sv/yuvsa_fwd.sv
module yuvsa_fwd #(
  parameter int FRAC_BITS = yuvsa_pkg::FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  yuvsa_pkg::ctl_t                      ctl_i,
  input  logic signed [yuvsa_pkg::DATA_W-1:0]  x_i [3],
  output yuvsa_pkg::ctl_t                      ctl_o,
  output logic signed [yuvsa_pkg::DATA_W-1:0]  x_o [3],
  output logic signed [yuvsa_pkg::T_W-1:0]     t_o [3]
);

  localparam int CW = FRAC_BITS + 3;
  localparam int PW = yuvsa_pkg::DATA_W + CW;
  localparam int AW = PW + 2;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

  yuvsa_pkg::ctl_t                     ctl1_r, ctl2_r;
  logic signed [PW-1:0]                prod_r [9];
  logic signed [yuvsa_pkg::DATA_W-1:0] x1_r [3];
  logic signed [yuvsa_pkg::DATA_W-1:0] x2_r [3];
  logic signed [yuvsa_pkg::T_W-1:0]    t_r [3];
  logic signed [yuvsa_pkg::T_W-1:0]    t_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r*3+c] <= PW'(yuvsa_pkg::fwd_coef(r*3+c, FRAC_BITS)) * PW'(x_i[c]);
      end
    end
    x1_r <= x_i;
  end

  // row sum, round half up by the fraction shift
  always_comb begin
    logic signed [AW-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = AW'(prod_r[r*3]) + AW'(prod_r[r*3+1]) + AW'(prod_r[r*3+2]) + HALF;
      t_nxt[r] = acc[FRAC_BITS +: yuvsa_pkg::T_W];
    end
  end

  always_ff @(posedge clk) begin
    t_r  <= t_nxt;
    x2_r <= x1_r;
  end

  assign ctl_o = ctl2_r;
  assign x_o   = x2_r;
  assign t_o   = t_r;

endmodule

>>> sv/yuvsa_gain.sv
module yuvsa_gain (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [yuvsa_pkg::GAIN_W-1:0]         gain_i,
  input  yuvsa_pkg::ctl_t                      ctl_i,
  input  logic signed [yuvsa_pkg::DATA_W-1:0]  x_i [3],
  input  logic signed [yuvsa_pkg::T_W-1:0]     t_i [3],
  output yuvsa_pkg::ctl_t                      ctl_o,
  output logic signed [yuvsa_pkg::S_W-1:0]     v_o [3],
  output logic signed [yuvsa_pkg::T_W-1:0]     t_o [3]
);

  localparam int GP_W = yuvsa_pkg::T_W + yuvsa_pkg::GAIN_W + 1;
  localparam logic signed [GP_W-1:0] HALF = GP_W'(1) << (yuvsa_pkg::GAIN_FRAC - 1);

  yuvsa_pkg::ctl_t                     ctl3_r, ctl4_r;
  logic signed [GP_W-1:0]              gp_r [2];
  logic signed [yuvsa_pkg::DATA_W-1:0] x3_r [3];
  logic signed [yuvsa_pkg::T_W-1:0]    t3_r [3];
  logic signed [yuvsa_pkg::T_W-1:0]    t4_r [3];
  logic signed [yuvsa_pkg::S_W-1:0]    v_r [3];
  logic signed [yuvsa_pkg::S_W-1:0]    v_nxt [3];
  logic signed [yuvsa_pkg::GAIN_W:0]   gain_s;

  assign gain_s = signed'({1'b0, gain_i});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl3_r <= ctl_i;
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      gp_r[k] <= GP_W'(t_i[k+1]) * GP_W'(gain_s);
    end
    x3_r <= x_i;
    t3_r <= t_i;
  end

  // pick the inverse matrix operands: raw YUV input, or Y with scaled chroma
  always_comb begin
    logic signed [GP_W-1:0] rnd;
    rnd = '0;
    if (ctl3_r.mode == yuvsa_pkg::MODE_YUV2RGB) begin
      for (int k = 0; k < 3; k++) begin
        v_nxt[k] = yuvsa_pkg::S_W'(x3_r[k]);
      end
    end else begin
      v_nxt[0] = yuvsa_pkg::S_W'(t3_r[0]);
      for (int k = 0; k < 2; k++) begin
        rnd        = gp_r[k] + HALF;
        v_nxt[k+1] = rnd[yuvsa_pkg::GAIN_FRAC +: yuvsa_pkg::S_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r  <= v_nxt;
    t4_r <= t3_r;
  end

  assign ctl_o = ctl4_r;
  assign v_o   = v_r;
  assign t_o   = t4_r;

endmodule

>>> sv/yuvsa_inv.sv
module yuvsa_inv #(
  parameter int FRAC_BITS = yuvsa_pkg::FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  yuvsa_pkg::ctl_t                      ctl_i,
  input  logic signed [yuvsa_pkg::S_W-1:0]     v_i [3],
  input  logic signed [yuvsa_pkg::T_W-1:0]     t_i [3],
  output logic                                 vld_o,
  output logic signed [yuvsa_pkg::DATA_W-1:0]  chan_o [3],
  output logic                                 clipped_o
);

  localparam int CW = FRAC_BITS + 3;
  localparam int PW = yuvsa_pkg::S_W + CW;
  localparam int AW = PW + 2;
  localparam int RW = yuvsa_pkg::R_W;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [RW-1:0] HI   = RW'(yuvsa_pkg::DATA_MAX);
  localparam logic signed [RW-1:0] LO   = RW'(yuvsa_pkg::DATA_MIN);

  yuvsa_pkg::ctl_t                     ctl5_r;
  logic signed [PW-1:0]                prod_r [9];
  logic signed [yuvsa_pkg::T_W-1:0]    t5_r [3];
  logic                                vld_r;
  logic signed [yuvsa_pkg::DATA_W-1:0] chan_r [3];
  logic signed [yuvsa_pkg::DATA_W-1:0] chan_nxt [3];
  logic                                clip_r, clip_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      ctl5_r <= ctl_i;
      vld_r  <= ctl5_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r*3+c] <= PW'(yuvsa_pkg::inv_coef(r*3+c, FRAC_BITS)) * PW'(v_i[c]);
      end
    end
    t5_r <= t_i;
  end

  // forward-only mode takes the YUV values straight through to saturation
  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [RW-1:0] res;
    clip_nxt = 1'b0;
    for (int r = 0; r < 3; r++) begin
      acc = AW'(prod_r[r*3]) + AW'(prod_r[r*3+1]) + AW'(prod_r[r*3+2]) + HALF;
      if (ctl5_r.mode == yuvsa_pkg::MODE_RGB2YUV) begin
        res = RW'(t5_r[r]);
      end else begin
        res = acc[FRAC_BITS +: RW];
      end
      if (res > HI) begin
        chan_nxt[r] = yuvsa_pkg::DATA_W'(HI);
        clip_nxt    = 1'b1;
      end else if (res < LO) begin
        chan_nxt[r] = yuvsa_pkg::DATA_W'(LO);
        clip_nxt    = 1'b1;
      end else begin
        chan_nxt[r] = res[yuvsa_pkg::DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    chan_r <= chan_nxt;
    clip_r <= clip_nxt;
  end

  assign vld_o     = vld_r;
  assign chan_o    = chan_r;
  assign clipped_o = clip_r;

endmodule

>>> sv/yuv_saturation_adjust.sv
// Per-pixel RGB/YUV colour converter (BT.601 analogue matrices, signed Q1.12
// components). mode 0 converts RGB to YUV, mode 1 YUV to RGB, mode 2 (and 3)
// converts RGB to YUV, scales U and V by sat_gain (Q4.12) and converts back.
// Every result component saturates to 14 bits and out_clipped flags any clip.
// One pixel is taken on every clock (busy is never raised) and its result
// appears on out_valid after the pipeline stages: two stages for the forward
// matrix, two for the chroma gain and operand select, two for the inverse
// matrix, rounding and saturation. Results cannot be held off, so capture
// every beat on which out_valid is high. Write mode and sat_gain only while
// no pixel is in flight.
module yuv_saturation_adjust #(
  parameter int FRAC_BITS = yuvsa_pkg::FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [yuvsa_pkg::DATA_W-1:0]  in_chan0_in,
  input  logic signed [yuvsa_pkg::DATA_W-1:0]  in_chan1_in,
  input  logic signed [yuvsa_pkg::DATA_W-1:0]  in_chan2_in,
  output logic                                 out_valid,
  output logic signed [yuvsa_pkg::DATA_W-1:0]  out_chan0_out,
  output logic signed [yuvsa_pkg::DATA_W-1:0]  out_chan1_out,
  output logic signed [yuvsa_pkg::DATA_W-1:0]  out_chan2_out,
  output logic                                 out_clipped,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [yuvsa_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_GAIN = 1'b1;

  logic [1:0]                          mode_r;
  logic [yuvsa_pkg::GAIN_W-1:0]        sat_gain_r;
  logic                                wr_en;
  logic                                reg_sel;
  yuvsa_pkg::ctl_t                     ctl_in, ctl_fwd, ctl_gain;
  logic signed [yuvsa_pkg::DATA_W-1:0] x_in [3];
  logic signed [yuvsa_pkg::DATA_W-1:0] x_fwd [3];
  logic signed [yuvsa_pkg::T_W-1:0]    t_fwd [3];
  logic signed [yuvsa_pkg::T_W-1:0]    t_gain [3];
  logic signed [yuvsa_pkg::S_W-1:0]    v_gain [3];
  logic signed [yuvsa_pkg::DATA_W-1:0] chan_out [3];

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= yuvsa_pkg::MODE_RESET;
      sat_gain_r <= yuvsa_pkg::GAIN_RESET;
    end else if (wr_en) begin
      if (reg_sel == REG_MODE) begin
        mode_r <= pwdata[1:0];
      end else begin
        sat_gain_r <= pwdata[yuvsa_pkg::GAIN_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODE: prdata = {30'd0, mode_r};
      REG_GAIN: prdata = {16'd0, sat_gain_r};
      default:  prdata = '0;
    endcase
  end

  assign busy        = 1'b0;
  assign ctl_in.vld  = start && !busy;
  assign ctl_in.mode = mode_r;
  assign x_in[0]     = in_chan0_in;
  assign x_in[1]     = in_chan1_in;
  assign x_in[2]     = in_chan2_in;

  yuvsa_fwd #(
    .FRAC_BITS(FRAC_BITS)
  ) u_fwd (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_in),
    .x_i   (x_in),
    .ctl_o (ctl_fwd),
    .x_o   (x_fwd),
    .t_o   (t_fwd)
  );

  yuvsa_gain u_gain (
    .clk    (clk),
    .rst_n  (rst_n),
    .gain_i (sat_gain_r),
    .ctl_i  (ctl_fwd),
    .x_i    (x_fwd),
    .t_i    (t_fwd),
    .ctl_o  (ctl_gain),
    .v_o    (v_gain),
    .t_o    (t_gain)
  );

  yuvsa_inv #(
    .FRAC_BITS(FRAC_BITS)
  ) u_inv (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl_gain),
    .v_i       (v_gain),
    .t_i       (t_gain),
    .vld_o     (out_valid),
    .chan_o    (chan_out),
    .clipped_o (out_clipped)
  );

  assign out_chan0_out = chan_out[0];
  assign out_chan1_out = chan_out[1];
  assign out_chan2_out = chan_out[2];

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef longint vec3_t [3];
  typedef int coef9_t [9];

  typedef struct {
    logic signed [yuvsa_pkg::DATA_W-1:0] c0;
    logic signed [yuvsa_pkg::DATA_W-1:0] c1;
    logic signed [yuvsa_pkg::DATA_W-1:0] c2;
    bit                                  clip;
  } pixel_t;

  // mode 3 is decoded like the saturation round trip
  localparam logic [1:0] MODE_SAT_ALIAS = 2'd3;

  localparam logic [yuvsa_pkg::ADDR_W-1:0] REG_MODE     = 3'd0;
  localparam logic [yuvsa_pkg::ADDR_W-1:0] REG_SAT_GAIN = 3'd4;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 100;

  // BT.601 matrices, each entry round(c * 4096) with ties away from zero
  localparam coef9_t FWD_Q12 = '{1225, 2404, 467, -602, -1184, 1786, 2519, -2109, -410};
  localparam coef9_t INV_Q12 = '{4096, 0, 4669, 4096, -1618, -2380, 4096, 8323, 0};

  class yuv_scoreboard;
    logic [1:0]                   mode;
    logic [yuvsa_pkg::GAIN_W-1:0] gain;
    pixel_t                       pending[$];
    int unsigned                  checked;
    int unsigned                  clip_count;
    int unsigned                  fail_count;
    int unsigned                  settings;

    function new();
      mode = yuvsa_pkg::MODE_RESET;
      gain = yuvsa_pkg::GAIN_RESET;
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function vec3_t apply(coef9_t m, vec3_t x);
      vec3_t y;
      for (int r = 0; r < 3; r++)
        y[r] = round_shift(m[3*r] * x[0] + m[3*r+1] * x[1] + m[3*r+2] * x[2],
                           yuvsa_pkg::FRAC_BITS);
      return y;
    endfunction

    function logic signed [yuvsa_pkg::DATA_W-1:0] clamp(longint v, inout bit hit);
      if (v > yuvsa_pkg::DATA_MAX) begin
        hit = 1'b1;
        return yuvsa_pkg::DATA_W'(yuvsa_pkg::DATA_MAX);
      end
      if (v < yuvsa_pkg::DATA_MIN) begin
        hit = 1'b1;
        return yuvsa_pkg::DATA_W'(yuvsa_pkg::DATA_MIN);
      end
      return yuvsa_pkg::DATA_W'(v);
    endfunction

    function void compare_field(string name, logic signed [31:0] exp_v,
                                logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        fail_count++;
      end
    endfunction

    function void note_pixel(logic signed [yuvsa_pkg::DATA_W-1:0] c0,
                             logic signed [yuvsa_pkg::DATA_W-1:0] c1,
                             logic signed [yuvsa_pkg::DATA_W-1:0] c2);
      vec3_t  x;
      vec3_t  t;
      vec3_t  y;
      longint g;
      pixel_t e;
      x = '{longint'(c0), longint'(c1), longint'(c2)};
      g = longint'(gain);
      case (mode)
        yuvsa_pkg::MODE_RGB2YUV: y = apply(FWD_Q12, x);
        yuvsa_pkg::MODE_YUV2RGB: y = apply(INV_Q12, x);
        default: begin
          // chroma scaled without saturation, only the final RGB clips
          t    = apply(FWD_Q12, x);
          t[1] = round_shift(t[1] * g, yuvsa_pkg::GAIN_FRAC);
          t[2] = round_shift(t[2] * g, yuvsa_pkg::GAIN_FRAC);
          y    = apply(INV_Q12, t);
        end
      endcase
      e.clip = 1'b0;
      e.c0   = clamp(y[0], e.clip);
      e.c1   = clamp(y[1], e.clip);
      e.c2   = clamp(y[2], e.clip);
      pending = {pending, e};
    endfunction

    function void check_result(logic signed [yuvsa_pkg::DATA_W-1:0] c0,
                               logic signed [yuvsa_pkg::DATA_W-1:0] c1,
                               logic signed [yuvsa_pkg::DATA_W-1:0] c2, logic clip);
      pixel_t e;
      if (pending.size() == 0) begin
        $error("result beat with no pixel outstanding");
        fail_count++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.clip)
        clip_count++;
      compare_field("chan0_out", e.c0, c0);
      compare_field("chan1_out", e.c1, c1);
      compare_field("chan2_out", e.c2, c2);
      compare_field("clipped", {31'd0, e.clip}, {31'd0, clip});
    endfunction
  endclass

  logic                                clk     = 1'b0;
  logic                                rst_n   = 1'b0;
  logic                                start   = 1'b0;
  logic signed [yuvsa_pkg::DATA_W-1:0] in_chan0_in = '0;
  logic signed [yuvsa_pkg::DATA_W-1:0] in_chan1_in = '0;
  logic signed [yuvsa_pkg::DATA_W-1:0] in_chan2_in = '0;
  logic                                psel    = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite  = 1'b0;
  logic [yuvsa_pkg::ADDR_W-1:0]        paddr   = '0;
  logic [31:0]                         pwdata  = '0;

  logic                                busy;
  logic                                out_valid;
  logic signed [yuvsa_pkg::DATA_W-1:0] out_chan0_out;
  logic signed [yuvsa_pkg::DATA_W-1:0] out_chan1_out;
  logic signed [yuvsa_pkg::DATA_W-1:0] out_chan2_out;
  logic                                out_clipped;
  logic [31:0]                         prdata;
  logic                                pready;

  yuv_scoreboard sb;
  int            burst_left = 0;

  int directed_pix [8][3] = '{
    '{0, 0, 0}, '{8191, 8191, 8191}, '{-8192, -8192, -8192}, '{8191, -8192, 8191},
    '{-8192, 8191, -8192}, '{4096, 4096, 4096}, '{4096, 0, 0}, '{-1, 1, -4096}
  };
  int corner_vals [4] = '{-8192, -1, 0, 8191};
  logic [1:0] phase_mode [PHASES] = '{
    yuvsa_pkg::MODE_RGB2YUV, yuvsa_pkg::MODE_YUV2RGB, yuvsa_pkg::MODE_SAT, MODE_SAT_ALIAS,
    yuvsa_pkg::MODE_SAT, yuvsa_pkg::MODE_SAT, yuvsa_pkg::MODE_SAT, yuvsa_pkg::MODE_RGB2YUV
  };
  int phase_gain [PHASES] = '{1, 65535, 0, 8192, 65535, 3000, 0, 4096};

  yuv_saturation_adjust dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_chan0_in   (in_chan0_in),
    .in_chan1_in   (in_chan1_in),
    .in_chan2_in   (in_chan2_in),
    .out_valid     (out_valid),
    .out_chan0_out (out_chan0_out),
    .out_chan1_out (out_chan1_out),
    .out_chan2_out (out_chan2_out),
    .out_clipped   (out_clipped),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk = ~clk;

  // results cannot be stalled, so take every beat
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_result(out_chan0_out, out_chan1_out, out_chan2_out, out_clipped);
  end

  task automatic send_pixel(logic signed [yuvsa_pkg::DATA_W-1:0] c0,
                            logic signed [yuvsa_pkg::DATA_W-1:0] c1,
                            logic signed [yuvsa_pkg::DATA_W-1:0] c2);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 19) == 0)
        burst_left = $urandom_range(8, 40);
    end
    // idle cycles carry junk data that must be ignored
    repeat (gap) begin
      start       <= 1'b0;
      in_chan0_in <= yuvsa_pkg::DATA_W'($urandom);
      in_chan1_in <= yuvsa_pkg::DATA_W'($urandom);
      in_chan2_in <= yuvsa_pkg::DATA_W'($urandom);
      @(posedge clk);
    end
    start       <= 1'b1;
    in_chan0_in <= c0;
    in_chan1_in <= c1;
    in_chan2_in <= c2;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_pixel(c0, c1, c2);
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // a write checks nothing; a read compares prdata with value
  task automatic apb_access(bit wr, logic [yuvsa_pkg::ADDR_W-1:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wr ? value : $urandom;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (!wr)
      sb.compare_field(addr == REG_MODE ? "mode readback" : "sat_gain readback",
                       value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [1:0] m, logic [yuvsa_pkg::GAIN_W-1:0] g);
    apb_access(1'b1, REG_MODE, {30'd0, m});
    apb_access(1'b1, REG_SAT_GAIN, {16'd0, g});
    sb.mode = m;
    sb.gain = g;
    sb.settings++;
    apb_access(1'b0, REG_MODE, {30'd0, m});
    apb_access(1'b0, REG_SAT_GAIN, {16'd0, g});
  endtask

  task automatic send_directed;
    foreach (directed_pix[i])
      send_pixel(yuvsa_pkg::DATA_W'(directed_pix[i][0]),
                 yuvsa_pkg::DATA_W'(directed_pix[i][1]),
                 yuvsa_pkg::DATA_W'(directed_pix[i][2]));
    drain();
  endtask

  initial begin
    logic signed [yuvsa_pkg::DATA_W-1:0] c [3];
    logic [yuvsa_pkg::GAIN_W-1:0]        g;
    sb = new();
    sb.settings = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings first, then each plain conversion
    send_directed();
    configure(yuvsa_pkg::MODE_RGB2YUV, yuvsa_pkg::GAIN_RESET);
    send_directed();
    configure(yuvsa_pkg::MODE_YUV2RGB, yuvsa_pkg::GAIN_RESET);
    send_directed();

    for (int p = 0; p < PHASES; p++) begin
      g = (p == 6) ? yuvsa_pkg::GAIN_W'($urandom_range(0, 65535))
                   : yuvsa_pkg::GAIN_W'(phase_gain[p]);
      configure(phase_mode[p], g);
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1:    foreach (c[k]) c[k] = yuvsa_pkg::DATA_W'(corner_vals[$urandom_range(0, 3)]);
          2, 3, 4: foreach (c[k]) c[k] = yuvsa_pkg::DATA_W'($urandom_range(0, 4096));
          default: foreach (c[k]) c[k] = yuvsa_pkg::DATA_W'($urandom_range(0, 16383));
        endcase
        send_pixel(c[0], c[1], c[2]);
      end
      drain();
    end

    // catch any stray beat after the pipeline empties
    repeat (12) @(posedge clk);

    $display("Checked %0d pixels under %0d register settings (modes 0 to 3, gains 0 to 65535).",
             sb.checked, sb.settings);
    $display("%0d results clipped, %0d mismatches.", sb.clip_count, sb.fail_count);
    if (sb.fail_count == 0 && sb.pending.size() == 0)
      $display("yuv_saturation_adjust test passed");
    else
      $display("yuv_saturation_adjust test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("yuv_saturation_adjust test failed");
    $finish;
  end

endmodule
